/* design/sbpf_pkg.sv */
// Shared definitions for the servo bus packet framer.
// Holds field layout, protocol constants, control structs and the CRC-16 step.
// No dependencies.
`timescale 1ns / 1ps

package sbpf_pkg;

  // Action codes carried in the command transfer.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_SYNC  = 2'd2;

  // Write data size codes.
  localparam logic [1:0] WSZ_1 = 2'd0;
  localparam logic [1:0] WSZ_2 = 2'd1;

  // Protocol bytes.
  localparam logic [7:0] HDR_FF     = 8'hFF;
  localparam logic [7:0] HDR_FD     = 8'hFD;
  localparam logic [7:0] HDR_RSV    = 8'h00;
  localparam logic [7:0] OPC_READ   = 8'h02;
  localparam logic [7:0] OPC_WRITE  = 8'h03;
  localparam logic [7:0] OPC_SYNC   = 8'h83;
  localparam logic [7:0] BCAST_ID   = 8'hFE;
  localparam logic [7:0] DATA_LEN4  = 8'h04;
  localparam logic [7:0] LEN_READ   = 8'h07;
  localparam logic [7:0] LEN_SYNC   = 8'h11;
  localparam logic [15:0] CRC_POLY  = 16'h8005;

  // Command transfer layout, lowest bit first.
  localparam int IN_W = 104;
  localparam int ACT_LSB  = 0;
  localparam int ID_LSB   = 2;
  localparam int ADDR_LSB = 10;
  localparam int WSZ_LSB  = 26;
  localparam int VAL1_LSB = 28;
  localparam int ID2_LSB  = 60;
  localparam int VAL2_LSB = 68;

  // Byte counter covers the longest packet of 24 bytes.
  localparam int IDX_W = 5;

  // Controller to datapath.
  typedef struct packed {
    logic load;  // capture a new command, clear counter and CRC
    logic step;  // produce the next packet byte into the output register
  } sbpf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic act_ok;  // the offered command has a defined action
    logic last;    // the byte about to be produced ends the packet
  } sbpf_stat_t;

  // One byte of CRC-16, polynomial 0x8005, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/sbpf_dp.sv */
// Datapath of the servo bus packet framer: command registers, byte counter,
// packet byte selection, running CRC and the output byte register.
// Depends on sbpf_pkg.
`timescale 1ns / 1ps

module sbpf_dp import sbpf_pkg::*; (
  input  logic             clk,
  input  sbpf_cmd_t        cmd,
  input  logic [IN_W-1:0]  in_tdata,
  output sbpf_stat_t       stat,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);

  logic [1:0]       act_r;
  logic [7:0]       id_r;
  logic [15:0]      addr_r;
  logic [1:0]       wsz_r;
  logic [31:0]      val1_r;
  logic [7:0]       id2_r;
  logic [31:0]      val2_r;
  logic [IDX_W-1:0] idx_r;
  logic [15:0]      crc_r;
  logic [7:0]       byte_r;
  logic             last_r;

  logic [IDX_W-1:0] pkt_len;
  logic [7:0]       len_lo;
  logic [7:0]       byte_nxt;
  logic [15:0]      crc_nxt;
  logic             is_crc_lo;
  logic             is_crc_hi;
  logic [1:0]       vsel;
  logic [1:0]       wsel;
  logic             act_ok;

  // Packet length including the two CRC bytes, and the low length field.
  always_comb begin
    unique case (act_r)
      ACT_WRITE: begin
        if (wsz_r == WSZ_1) begin
          pkt_len = IDX_W'(13);
          len_lo  = 8'd6;
        end else if (wsz_r == WSZ_2) begin
          pkt_len = IDX_W'(14);
          len_lo  = 8'd7;
        end else begin
          pkt_len = IDX_W'(16);
          len_lo  = 8'd9;
        end
      end
      ACT_READ: begin
        pkt_len = IDX_W'(14);
        len_lo  = LEN_READ;
      end
      default: begin
        pkt_len = IDX_W'(24);
        len_lo  = LEN_SYNC;
      end
    endcase
  end

  assign is_crc_lo = (idx_r == IDX_W'(pkt_len - IDX_W'(2)));
  assign is_crc_hi = (idx_r == IDX_W'(pkt_len - IDX_W'(1)));

  // Byte lane selects for the little-endian value fields of a sync write.
  always_comb begin
    case (idx_r)
      IDX_W'(10), IDX_W'(13), IDX_W'(18): vsel = 2'd0;
      IDX_W'(11), IDX_W'(14), IDX_W'(19): vsel = 2'd1;
      IDX_W'(12), IDX_W'(15), IDX_W'(20): vsel = 2'd2;
      default:                            vsel = 2'd3;
    endcase
  end

  // A write's value starts at byte 10, so its lane is the counter minus ten.
  assign wsel = idx_r[1:0] + 2'd2;

  always_comb begin
    byte_nxt = 8'h00;
    if (is_crc_lo) begin
      byte_nxt = crc_r[7:0];
    end else if (is_crc_hi) begin
      byte_nxt = crc_r[15:8];
    end else begin
      case (idx_r)
        IDX_W'(0), IDX_W'(1): byte_nxt = HDR_FF;
        IDX_W'(2):            byte_nxt = HDR_FD;
        IDX_W'(3):            byte_nxt = HDR_RSV;
        IDX_W'(4):            byte_nxt = (act_r == ACT_SYNC) ? BCAST_ID : id_r;
        IDX_W'(5):            byte_nxt = len_lo;
        IDX_W'(6):            byte_nxt = 8'h00;
        IDX_W'(7): begin
          case (act_r)
            ACT_WRITE: byte_nxt = OPC_WRITE;
            ACT_READ:  byte_nxt = OPC_READ;
            default:   byte_nxt = OPC_SYNC;
          endcase
        end
        IDX_W'(8):            byte_nxt = addr_r[7:0];
        IDX_W'(9):            byte_nxt = addr_r[15:8];
        default: begin
          if (act_r == ACT_WRITE) begin
            // Value bytes start right after the address.
            byte_nxt = val1_r[{wsel, 3'b000} +: 8];
          end else if (idx_r == IDX_W'(10)) begin
            byte_nxt = DATA_LEN4;
          end else if (idx_r == IDX_W'(11)) begin
            byte_nxt = 8'h00;
          end else if (idx_r == IDX_W'(12)) begin
            byte_nxt = id_r;
          end else if (idx_r == IDX_W'(17)) begin
            byte_nxt = id2_r;
          end else if (idx_r < IDX_W'(17)) begin
            byte_nxt = val1_r[{vsel, 3'b000} +: 8];
          end else begin
            byte_nxt = val2_r[{vsel, 3'b000} +: 8];
          end
        end
      endcase
    end
  end

  assign crc_nxt = crc16_byte(crc_r, byte_nxt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_tdata[ACT_LSB  +: 2];
      id_r   <= in_tdata[ID_LSB   +: 8];
      addr_r <= in_tdata[ADDR_LSB +: 16];
      wsz_r  <= in_tdata[WSZ_LSB  +: 2];
      val1_r <= in_tdata[VAL1_LSB +: 32];
      id2_r  <= in_tdata[ID2_LSB  +: 8];
      val2_r <= in_tdata[VAL2_LSB +: 32];
      idx_r  <= '0;
      crc_r  <= '0;
    end else if (cmd.step) begin
      idx_r  <= idx_r + IDX_W'(1);
      byte_r <= byte_nxt;
      last_r <= is_crc_hi;
      // The CRC stops running once its own bytes are being sent.
      if (!is_crc_lo && !is_crc_hi) begin
        crc_r <= crc_nxt;
      end
    end
  end

  assign act_ok = (in_tdata[ACT_LSB +: 2] == ACT_WRITE) ||
                  (in_tdata[ACT_LSB +: 2] == ACT_READ) ||
                  (in_tdata[ACT_LSB +: 2] == ACT_SYNC);
  assign stat   = '{act_ok: act_ok, last: is_crc_hi};

  assign out_tdata = byte_r;
  assign out_tlast = last_r;

endmodule

/* design/sbpf_ctrl.sv */
// Controller of the servo bus packet framer: idle/send state machine and the
// output valid flag.
// Depends on sbpf_pkg.
`timescale 1ns / 1ps

module sbpf_ctrl import sbpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic       out_tready,
  output logic       out_tvalid,
  input  sbpf_stat_t stat,
  output sbpf_cmd_t  cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic state_r, state_nxt;
  logic ovld_r, ovld_nxt;
  logic slot_free;

  assign slot_free = !ovld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        // Commands with an undefined action are taken and dropped.
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (stat.act_ok) begin
            state_nxt = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        if (slot_free) begin
          cmd.step = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.step) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;

endmodule

/* design/servo_bus_packet_framer.sv */
// Top level of the servo bus packet framer: joins controller and datapath.
// Depends on sbpf_pkg, sbpf_ctrl and sbpf_dp.
`timescale 1ns / 1ps
//
// Usage:
// The slave-side stream takes one command per transfer. Each defined command
// is expanded into a complete protocol 2.0 instruction packet on the
// master-side stream, one byte per transfer, with out_tlast high on the CRC
// high byte that closes the packet. A write gives 13, 14 or 16 bytes, a read
// request 14 bytes and a broadcast sync write 24 bytes. The trailing CRC-16
// (polynomial 0x8005, initial value zero) is accumulated byte by byte as the
// packet is produced, so no byte buffer is needed.
// The command is captured at its transfer; its bytes are then produced into the
// single byte-wide output register. With out_tready held high, the framer
// emits one byte per cycle. A command with an undefined action is accepted
// and dropped without any output.
// in_tready is high only while no packet is being generated; the next command
// is taken while the final byte still waits in the output register.
// When the receiver stalls, the output byte holds and generation pauses.
// Reset (rst_n low, synchronous) returns the controller to idle and empties
// the output register.

module servo_bus_packet_framer import sbpf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // Fields from bit 0 up: action[1:0], servo_id[7:0], address[15:0],
  // write_size[1:0], write_value[31:0], second_id[7:0], second_value[31:0],
  // then four zero fill bits.
  input  logic [IN_W-1:0] in_tdata,
  output logic            out_tvalid,
  input  logic            out_tready,
  // Fields from bit 0 up: tx_byte[7:0].
  output logic [7:0]      out_tdata,
  output logic            out_tlast
);

  sbpf_cmd_t  cmd;
  sbpf_stat_t stat;

  // Sequencing of commands and the output valid flag.
  sbpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Command capture, byte generation and CRC accumulation.
  sbpf_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .in_tdata  (in_tdata),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

/* sim/sbpf_packet_check.sv */
// Checker for the servo bus packet framer: predicts every packet byte from the
// command transfers and compares the byte stream against it.
// Depends on sbpf_pkg for the command width and the action and size codes.
`timescale 1ns / 1ps

module sbpf_packet_check import sbpf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [7:0]      out_tdata,
  input  logic            out_tlast,
  output int              fail_count,
  output int              bytes_owed
);

  // Protocol bytes, kept separate from the design's own definitions.
  localparam logic [7:0]  PK_LEAD   = 8'hFF;
  localparam logic [7:0]  PK_MARK   = 8'hFD;
  localparam logic [7:0]  PK_RSV    = 8'h00;
  localparam logic [7:0]  OP_READ   = 8'h02;
  localparam logic [7:0]  OP_WRITE  = 8'h03;
  localparam logic [7:0]  OP_SYNC   = 8'h83;
  localparam logic [7:0]  ID_ALL    = 8'hFE;
  localparam logic [15:0] READ_SPAN = 16'd4;
  localparam logic [15:0] CRC_GEN   = 16'h8005;
  // The length field counts instruction, address and CRC on top of the parameters.
  localparam int          LEN_FIXED = 5;
  localparam int          REPORT_MAX = 10;

  // Command layout, lowest bit last in the declaration.
  typedef struct packed {
    logic [3:0]  fill;
    logic [31:0] value_b;
    logic [7:0]  id_b;
    logic [31:0] value_a;
    logic [1:0]  size;
    logic [15:0] addr;
    logic [7:0]  id;
    logic [1:0]  action;
  } command_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } bus_byte_t;

  bus_byte_t   owed_q[$];
  logic [15:0] crc_acc;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ b[i];
      crc = {crc[14:0], 1'b0} ^ (fb ? CRC_GEN : 16'h0000);
    end
    return crc;
  endfunction

  task automatic owe_byte(input logic [7:0] b);
    owed_q.push_back('{data: b, last: 1'b0});
    crc_acc = crc_add(crc_acc, b);
  endtask

  // Expands one command into the bytes of its instruction packet.
  task automatic frame_command(input command_t c);
    logic [95:0] params;
    logic [7:0]  target;
    logic [7:0]  op;
    logic [15:0] plen;
    int          pcount;
    if (c.action == ACT_WRITE) begin
      pcount = (c.size == WSZ_1) ? 1 : (c.size == WSZ_2) ? 2 : 4;
      params = {64'h0, c.value_a};
      target = c.id;
      op     = OP_WRITE;
    end else if (c.action == ACT_READ) begin
      pcount = 2;
      params = {80'h0, READ_SPAN};
      target = c.id;
      op     = OP_READ;
    end else if (c.action == ACT_SYNC) begin
      pcount = 12;
      params = {c.value_b, c.id_b, c.value_a, c.id, READ_SPAN};
      target = ID_ALL;
      op     = OP_SYNC;
    end else begin
      return;
    end
    plen    = 16'(LEN_FIXED + pcount);
    crc_acc = 16'h0000;
    owe_byte(PK_LEAD);
    owe_byte(PK_LEAD);
    owe_byte(PK_MARK);
    owe_byte(PK_RSV);
    owe_byte(target);
    owe_byte(plen[7:0]);
    owe_byte(plen[15:8]);
    owe_byte(op);
    owe_byte(c.addr[7:0]);
    owe_byte(c.addr[15:8]);
    for (int k = 0; k < pcount; k++) begin
      owe_byte(params[8*k +: 8]);
    end
    owed_q.push_back('{data: crc_acc[7:0], last: 1'b0});
    owed_q.push_back('{data: crc_acc[15:8], last: 1'b1});
  endtask

  task automatic flag(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    bus_byte_t want;
    if (!rst_n) begin
      owed_q.delete();
      fail_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        frame_command(command_t'(in_tdata));
      end
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          flag($sformatf("byte %h with no packet owed", out_tdata));
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.data) begin
            flag($sformatf("tx byte: expected %h, got %h", want.data, out_tdata));
          end
          if (out_tlast !== want.last) begin
            flag($sformatf("last flag: expected %b, got %b", want.last, out_tlast));
          end
        end
      end
    end
    bytes_owed = owed_q.size();
  end

endmodule

/* sim/testbench.sv */
// Top of the framer testbench: clock, reset, command stimulus, receiver stalls,
// watchdog and verdict. Depends on sbpf_pkg, servo_bus_packet_framer and
// sbpf_packet_check.
`timescale 1ns / 1ps

module testbench;
  import sbpf_pkg::*;

  // Codes the package leaves unnamed: the four-byte size, the size code that
  // the framer must treat as four bytes, and the action it must drop.
  localparam logic [1:0] WSZ_4    = 2'd2;
  localparam logic [1:0] WSZ_ODD  = 2'd3;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam int RANDOM_CMDS = 144;   // defined commands in the random part
  localparam int HOLD_AT     = 400;   // bytes received before the long stall
  localparam int STALL_SPAN  = 300;   // length of the long receiver stall
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer
  localparam int DRAIN       = 40;    // quiet cycles before the verdict

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            in_tvalid  = 1'b0;
  logic [IN_W-1:0] in_tdata   = '0;
  logic            out_tready = 1'b0;
  logic            in_tready;
  logic            out_tvalid;
  logic [7:0]      out_tdata;
  logic            out_tlast;

  int fail_count;
  int bytes_owed;
  int burst_left  = 0;
  int idle_cycles = 0;
  int rx_cyc      = 0;
  int rx_bytes    = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  servo_bus_packet_framer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // The checker sees both channels, predicts each packet and counts failures.
  sbpf_packet_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  // Packs the command fields from bit 0 up; the four top bits stay zero.
  function automatic logic [IN_W-1:0] pack_cmd(input logic [1:0] act, input logic [7:0] id,
                                               input logic [15:0] addr, input logic [1:0] wsz,
                                               input logic [31:0] v1, input logic [7:0] id2,
                                               input logic [31:0] v2);
    return {4'b0000, v2, id2, v1, wsz, addr, id, act};
  endfunction

  // Offers one command and returns at the edge where its transfer happens.
  // Commands go out in bursts; between bursts tvalid drops for a random gap.
  // A gap of zero keeps tvalid high, so some bursts run back to back.
  task automatic send_cmd(input logic [IN_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Stops offering and waits until every owed byte has been received. The
  // owed count is read at the falling edge, after the checker has updated it.
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (bytes_owed != 0);
    @(posedge clk);
  endtask

  // Receiver. Its ready pattern cycles through four phases: always ready, mostly
  // ready, a fixed one-in-three stall, and mostly stalled. Once, after enough
  // bytes have arrived, it holds off for a long stretch so that the framer's
  // output register fills and in_tready stays low while commands are offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (out_tvalid && out_tready) begin
        rx_bytes <= rx_bytes + 1;
      end
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (!hold_done && rx_bytes >= HOLD_AT) begin
        hold_done  <= 1'b1;
        hold_left  <= STALL_SPAN;
        out_tready <= 1'b0;
      end else begin
        case ((rx_cyc / 160) % 4)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= ($urandom_range(0, 9) < 7);
          end
          2: begin
            out_tready <= (rx_cyc % 3 != 0);
          end
          default: begin
            out_tready <= ($urandom_range(0, 9) < 3);
          end
        endcase
      end
    end
  end

  // Watchdog: a correct run never goes this long without a transfer on either
  // channel, the long receiver stall included.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int         sent;
    logic [1:0] act;
    logic [1:0] wsz;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed commands: every action, every size code, field extremes, and
    // junk in the fields that an action does not use.
    send_cmd(pack_cmd(ACT_WRITE, 8'h00, 16'h0000, WSZ_1, 32'h0000_0000, 8'h00, 32'h0));
    send_cmd(pack_cmd(ACT_WRITE, 8'hFF, 16'hFFFF, WSZ_1, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    send_cmd(pack_cmd(ACT_WRITE, 8'h01, 16'h0074, WSZ_2, 32'h1234_ABCD, 8'h5A, 32'h0));
    send_cmd(pack_cmd(ACT_WRITE, 8'hFE, 16'h8000, WSZ_2, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF));
    send_cmd(pack_cmd(ACT_WRITE, 8'h80, 16'h0001, WSZ_4, 32'hFFFF_FFFF, 8'hFF, 32'h0));
    send_cmd(pack_cmd(ACT_WRITE, 8'h7F, 16'hFFFF, WSZ_4, 32'h8000_0001, 8'h00, 32'h0));
    // The undefined size code must behave as four bytes.
    send_cmd(pack_cmd(ACT_WRITE, 8'h03, 16'h1234, WSZ_ODD, 32'hDEAD_BEEF, 8'h00, 32'h0));
    send_cmd(pack_cmd(ACT_READ, 8'h00, 16'h0000, WSZ_1, 32'h0, 8'h00, 32'h0));
    send_cmd(pack_cmd(ACT_READ, 8'hFF, 16'hFFFF, WSZ_ODD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    send_cmd(pack_cmd(ACT_READ, 8'h2A, 16'h0084, WSZ_2, $urandom, 8'($urandom), $urandom));
    // A command with the undefined action is taken and dropped.
    send_cmd(pack_cmd(ACT_NONE, 8'hFF, 16'hFFFF, WSZ_ODD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    send_cmd(pack_cmd(ACT_SYNC, 8'h00, 16'h0000, WSZ_1, 32'h0000_0000, 8'h00, 32'h0000_0000));
    send_cmd(pack_cmd(ACT_SYNC, 8'hFF, 16'hFFFF, WSZ_ODD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
    send_cmd(pack_cmd(ACT_NONE, 8'h00, 16'h0000, WSZ_1, 32'h0, 8'h00, 32'h0));
    send_cmd(pack_cmd(ACT_SYNC, 8'h01, 16'h0074, WSZ_2, 32'h0000_0800, 8'h02, 32'hFFFF_F800));
    send_cmd(pack_cmd(ACT_WRITE, 8'h05, 16'h0040, WSZ_1, 32'hFFFF_FF01, 8'hAA, 32'h5555_5555));
    wait_drained();

    // Random commands. A few use the undefined action as noise; only the
    // defined ones count. Halfway through, the sender pauses until every
    // owed byte has arrived.
    sent = 0;
    while (sent < RANDOM_CMDS) begin
      if (sent == RANDOM_CMDS / 2) begin
        wait_drained();
      end
      act = ($urandom_range(0, 99) < 8) ? ACT_NONE : 2'($urandom_range(0, 2));
      wsz = 2'($urandom_range(0, 3));
      send_cmd(pack_cmd(act, 8'($urandom), 16'($urandom), wsz, $urandom, 8'($urandom),
                        $urandom));
      if (act != ACT_NONE) begin
        sent++;
      end
    end

    // Drain, then let a few quiet cycles pass so that a stray byte is caught.
    wait_drained();
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
